// ----- hw/rtl/hpq_pkg.sv -----
`default_nettype none

package hpq_pkg;

  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned LenW              = 8;
  localparam int unsigned RepW              = 4;
  localparam int unsigned StrW              = 3;
  localparam int unsigned DutyW             = 7;
  localparam int unsigned CfgIdxW           = 1;
  localparam int unsigned CfgDataW          = 8;
  localparam int unsigned DutyStep          = 20;
  localparam int unsigned DutyMax           = 100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRENGTH   = 1'b0,
    CFG_DRIVE_MODE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_PLAY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic            clear;
    logic            push;
    logic            load;
    logic [LenW-1:0] len;
    logic [LenW-1:0] pau;
    logic [RepW-1:0] rep;
  } ring_ctrl_t;

  typedef struct packed {
    logic            empty;
    logic [LenW-1:0] len;
    logic [LenW-1:0] pau;
    logic [RepW-1:0] rep;
  } ring_head_t;

  function automatic logic [DutyW-1:0] duty_of(logic [StrW-1:0] s);
    logic [DutyW:0] d;
    d = (DutyW+1)'(s) * (DutyW+1)'(DutyStep);
    if (d > (DutyW+1)'(DutyMax)) begin
      return DutyW'(DutyMax);
    end
    return d[DutyW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hpq_if.sv -----
`default_nettype none

interface hpq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [hpq_pkg::LenW-1:0]     buzz_length;
  logic [hpq_pkg::LenW-1:0]     pause_length;
  logic [hpq_pkg::RepW-1:0]     repeat_count;
  logic                         preempt;

  modport source (output valid, cmd, buzz_length, pause_length, repeat_count, preempt,
                  input ready);
  modport sink   (input valid, cmd, buzz_length, pause_length, repeat_count, preempt,
                  output ready);
endinterface

interface hpq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         motor_on;
  logic [hpq_pkg::DutyW-1:0]    duty_percent;
  logic                         busy_res;
  logic                         queue_pending;

  modport source (output valid, motor_on, duty_percent, busy_res, queue_pending,
                  input ready);
  modport sink   (input valid, motor_on, duty_percent, busy_res, queue_pending,
                  output ready);
endinterface

interface hpq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hpq_pkg::CfgIdxW-1:0]   index;
  logic [hpq_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hpq_ring.sv -----
`default_nettype none

module hpq_ring #(
  parameter int unsigned QUEUE_DEPTH = hpq_pkg::QueueDepthDefault,
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire hpq_pkg::ring_ctrl_t ctrl_i,
  output hpq_pkg::ring_head_t      head_o,
  output logic                     pending_o
);

  logic [hpq_pkg::LenW-1:0] len_q [QUEUE_DEPTH];
  logic [hpq_pkg::LenW-1:0] pau_q [QUEUE_DEPTH];
  logic [hpq_pkg::RepW-1:0] rep_q [QUEUE_DEPTH];

  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [PtrW-1:0] push_slot, push_next, rd_next;
  logic            push_ok;
  logic            pop;

  function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head_o.empty = (rd_q == wr_q);
  assign head_o.len   = len_q[rd_q];
  assign head_o.pau   = pau_q[rd_q];
  assign head_o.rep   = rep_q[rd_q];

  assign push_slot = ctrl_i.clear ? rd_q : wr_q;
  assign push_next = nxt(push_slot);
  assign push_ok   = ctrl_i.push && (push_next != rd_q);
  assign rd_next   = nxt(rd_q);
  assign pop       = ctrl_i.load && (head_o.rep == '0);

  always_comb begin
    rd_d = rd_q;
    wr_d = wr_q;
    if (ctrl_i.clear) begin
      wr_d = rd_q;
    end
    if (push_ok) begin
      wr_d = push_next;
    end
    if (pop) begin
      rd_d = rd_next;
    end
  end

  assign pending_o = (rd_d != wr_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else if (en_i) begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && push_ok) begin
      len_q[push_slot] <= ctrl_i.len;
      pau_q[push_slot] <= ctrl_i.pau;
      rep_q[push_slot] <= ctrl_i.rep;
    end else if (en_i && ctrl_i.load && !pop) begin
      rep_q[rd_q] <= head_o.rep - hpq_pkg::RepW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpq_timer.sv -----
`default_nettype none

module hpq_timer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        cmd_i,
  input  wire logic [hpq_pkg::LenW-1:0]    buzz_length_i,
  input  wire logic [hpq_pkg::LenW-1:0]    pause_length_i,
  input  wire logic [hpq_pkg::RepW-1:0]    repeat_count_i,
  input  wire logic                        preempt_i,
  input  wire logic [hpq_pkg::StrW-1:0]    strength_i,
  input  wire logic                        drive_mode_i,
  input  wire hpq_pkg::ring_head_t         head_i,
  output hpq_pkg::ring_ctrl_t              ctrl_o,
  output logic                             motor_o,
  output logic                             busy_o
);

  logic [hpq_pkg::LenW-1:0] buzz_q, buzz_d;
  logic [hpq_pkg::LenW-1:0] pause_q, pause_d;
  logic [hpq_pkg::StrW-1:0] pulse_q, pulse_d;
  logic                     motor_q, motor_d;
  logic                     busy;
  logic                     start;

  assign busy  = (buzz_q != '0) || (pause_q != '0);
  assign start = preempt_i || (!busy && head_i.empty);

  always_comb begin
    buzz_d      = buzz_q;
    pause_d     = pause_q;
    pulse_d     = pulse_q;
    motor_d     = motor_q;
    ctrl_o      = '0;
    ctrl_o.len  = buzz_length_i;
    ctrl_o.pau  = pause_length_i;
    ctrl_o.rep  = repeat_count_i;
    if (cmd_i == hpq_pkg::CMD_PLAY) begin
      if (start) begin
        buzz_d       = buzz_length_i;
        pause_d      = pause_length_i;
        ctrl_o.clear = 1'b1;
        ctrl_o.rep   = repeat_count_i - hpq_pkg::RepW'(1);
        ctrl_o.push  = (repeat_count_i != '0);
      end else begin
        ctrl_o.push  = (repeat_count_i != '1);
      end
    end else if (buzz_q != '0) begin
      buzz_d = buzz_q - hpq_pkg::LenW'(1);
      if (drive_mode_i) begin
        motor_d = 1'b1;
      end else if (pulse_q != '0) begin
        pulse_d = pulse_q - hpq_pkg::StrW'(1);
        motor_d = 1'b1;
      end else begin
        motor_d = 1'b0;
        pulse_d = strength_i;
      end
    end else begin
      motor_d = 1'b0;
      if (pause_q != '0) begin
        pause_d = pause_q - hpq_pkg::LenW'(1);
      end else if (!head_i.empty) begin
        buzz_d      = head_i.len;
        pause_d     = head_i.pau;
        ctrl_o.load = 1'b1;
      end
    end
  end

  assign motor_o = motor_d;
  assign busy_o  = (buzz_d != '0) || (pause_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buzz_q  <= '0;
      pause_q <= '0;
      pulse_q <= '0;
      motor_q <= 1'b0;
    end else if (en_i) begin
      buzz_q  <= buzz_d;
      pause_q <= pause_d;
      pulse_q <= pulse_d;
      motor_q <= motor_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/haptic_pattern_queue.sv -----
// An item is captured in the input register; its result is registered in the output register when it advances.
// Throughput: one item per cycle; a waiting result holds the input register.
// The ring is a register file read at the head pointer, so a tick finishes in one pass.
// Reset clears timers, pointers, motor level, configuration registers and valid flags at once;
// ring contents are not cleared and are never read before being written.
`default_nettype none

module haptic_pattern_queue #(
  parameter int unsigned QUEUE_DEPTH = hpq_pkg::QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hpq_in_if.sink     in_i,
  hpq_cfg_if.sink    cfg_i,
  hpq_out_if.source  res_o
);

  logic                        strength_we, drive_mode_we;
  logic [hpq_pkg::StrW-1:0]    strength_q;
  logic                        drive_mode_q;

  logic                        s1_valid_q;
  logic                        cmd_q;
  logic [hpq_pkg::LenW-1:0]    buzz_length_q;
  logic [hpq_pkg::LenW-1:0]    pause_length_q;
  logic [hpq_pkg::RepW-1:0]    repeat_count_q;
  logic                        preempt_q;
  logic                        advance;

  logic                        out_valid_q;
  logic                        motor_on_q;
  logic [hpq_pkg::DutyW-1:0]   duty_q;
  logic                        busy_res_q;
  logic                        pending_q;

  hpq_pkg::ring_ctrl_t         ring_ctrl;
  hpq_pkg::ring_head_t         ring_head;
  logic                        pending_d;
  logic                        motor_d;
  logic                        busy_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    strength_we   = 1'b0;
    drive_mode_we = 1'b0;
    unique case (hpq_pkg::cfg_reg_e'(cfg_i.index))
      hpq_pkg::CFG_STRENGTH:   strength_we   = cfg_i.valid;
      hpq_pkg::CFG_DRIVE_MODE: drive_mode_we = cfg_i.valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q   <= '0;
      drive_mode_q <= 1'b0;
    end else begin
      if (strength_we) begin
        strength_q <= cfg_i.data[hpq_pkg::StrW-1:0];
      end
      if (drive_mode_we) begin
        drive_mode_q <= cfg_i.data[0];
      end
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q          <= in_i.cmd;
      buzz_length_q  <= in_i.buzz_length;
      pause_length_q <= in_i.pause_length;
      repeat_count_q <= in_i.repeat_count;
      preempt_q      <= in_i.preempt;
    end
  end

  hpq_timer u_timer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .cmd_i          (cmd_q),
    .buzz_length_i  (buzz_length_q),
    .pause_length_i (pause_length_q),
    .repeat_count_i (repeat_count_q),
    .preempt_i      (preempt_q),
    .strength_i     (strength_q),
    .drive_mode_i   (drive_mode_q),
    .head_i         (ring_head),
    .ctrl_o         (ring_ctrl),
    .motor_o        (motor_d),
    .busy_o         (busy_d)
  );

  hpq_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .ctrl_i    (ring_ctrl),
    .head_o    (ring_head),
    .pending_o (pending_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      motor_on_q <= motor_d;
      duty_q     <= (drive_mode_q && motor_d) ? hpq_pkg::duty_of(strength_q) : '0;
      busy_res_q <= busy_d;
      pending_q  <= pending_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.motor_on      = motor_on_q;
  assign res_o.duty_percent  = duty_q;
  assign res_o.busy_res      = busy_res_q;
  assign res_o.queue_pending = pending_q;

endmodule

`default_nettype wire

// ----- bench/tb_haptic_pattern_queue.sv -----
`timescale 1ns / 1ps

module tb_haptic_pattern_queue;
  import hpq_pkg::*;

  localparam int unsigned Depth       = QueueDepthDefault;
  localparam int unsigned PtrW        = $clog2(Depth);
  localparam int unsigned SettleCyc   = 4;
  localparam int unsigned HoldCyc     = 300;
  localparam int unsigned LimitCyc    = 600000;
  localparam int unsigned RandomItems = 1250;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_DRAIN
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e      kind;
    cmd_e            cmd;
    logic [LenW-1:0] len;
    logic [LenW-1:0] pau;
    logic [RepW-1:0] rep;
    logic            now;
    cfg_reg_e        idx;
    logic [7:0]      data;
    logic [7:0]      gap;
    logic            hold;
  } stim_op_t;

  typedef struct packed {
    logic             motor;
    logic [DutyW-1:0] duty;
    logic             busy;
    logic             pending;
  } motor_status_t;

  logic clk_i;
  logic rst_ni;

  hpq_in_if  in_if ();
  hpq_cfg_if cfg_if ();
  hpq_out_if res_if ();

  haptic_pattern_queue uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  stim_op_t      pending_q[$];
  motor_status_t motor_status_q[$];

  int unsigned sent_count;
  int unsigned rx_count;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  logic        hold_go;
  logic        stim_done;
  bit          dense_mode;

  // predictor state
  logic [LenW-1:0] buzz_cnt;
  logic [LenW-1:0] pause_cnt;
  logic [7:0]      pulse_cnt;
  logic [PtrW-1:0] head_ptr;
  logic [PtrW-1:0] tail_ptr;
  logic [LenW-1:0] len_mem [Depth];
  logic [LenW-1:0] pau_mem [Depth];
  logic [RepW-1:0] rep_mem [Depth];
  logic            motor_lvl;
  logic [StrW-1:0] strength_reg;
  logic            pwm_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LenW-1:0] pick_span(int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return LenW'($urandom_range(0, 255));
    end
    if (r < 6) begin
      return '0;
    end
    return LenW'($urandom_range(0, top));
  endfunction

  task automatic add_item(input cmd_e c, input logic [LenW-1:0] l, input logic [LenW-1:0] p,
                          input logic [RepW-1:0] r, input logic n, input bit hold);
    stim_op_t op;
    op      = '0;
    op.kind = OP_ITEM;
    op.cmd  = c;
    op.len  = l;
    op.pau  = p;
    op.rep  = r;
    op.now  = n;
    op.gap  = dense_mode ? 8'd0 : 8'(pick_gap());
    op.hold = hold;
    pending_q.push_back(op);
  endtask

  task automatic add_play(input logic [LenW-1:0] l, input logic [LenW-1:0] p,
                          input logic [RepW-1:0] r, input logic n);
    add_item(CMD_PLAY, l, p, r, n, 1'b0);
  endtask

  task automatic add_ticks(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      add_item(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    end
  endtask

  task automatic add_cfg(input cfg_reg_e idx, input logic [7:0] data);
    stim_op_t op;
    op      = '0;
    op.kind = OP_CFG;
    op.idx  = idx;
    op.data = data;
    pending_q.push_back(op);
  endtask

  task automatic add_drain();
    stim_op_t op;
    op      = '0;
    op.kind = OP_DRAIN;
    pending_q.push_back(op);
  endtask

  task automatic add_random_item(input bit hold);
    if ($urandom_range(0, 99) < 70) begin
      if ($urandom_range(0, 2) == 0) begin
        add_item(CMD_TICK, LenW'($urandom), LenW'($urandom), RepW'($urandom_range(0, 14)),
                 1'($urandom), hold);
      end else begin
        add_item(CMD_TICK, '0, '0, '0, 1'b0, hold);
      end
    end else begin
      add_item(CMD_PLAY, pick_span(6), pick_span(4),
               ($urandom_range(0, 9) < 7) ? RepW'($urandom_range(0, 3))
                                          : RepW'($urandom_range(0, 14)),
               ($urandom_range(0, 6) == 0), hold);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 40) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic predict_motor(input cmd_e c, input logic [LenW-1:0] l,
                               input logic [LenW-1:0] p, input logic [RepW-1:0] r,
                               input logic n, output motor_status_t st);
    logic            busy;
    logic            empty;
    logic [RepW:0]   flags;
    logic [PtrW-1:0] nxt;
    int unsigned     duty;
    if (c == CMD_PLAY) begin
      busy  = (buzz_cnt != 0) || (pause_cnt != 0);
      empty = (head_ptr == tail_ptr);
      flags = {1'b0, r};
      if (n || (!busy && empty)) begin
        buzz_cnt  = l;
        pause_cnt = p;
        tail_ptr  = head_ptr;
      end else begin
        flags = flags + 1'b1;
      end
      if (flags[RepW-1:0] != 0) begin
        nxt = PtrW'((tail_ptr + 1) % Depth);
        if (nxt != head_ptr) begin
          len_mem[tail_ptr] = l;
          pau_mem[tail_ptr] = p;
          rep_mem[tail_ptr] = flags[RepW-1:0] - 1'b1;
          tail_ptr          = nxt;
        end
      end
    end else if (buzz_cnt != 0) begin
      buzz_cnt = buzz_cnt - 1'b1;
      if (pwm_mode) begin
        motor_lvl = 1'b1;
      end else if (pulse_cnt != 0) begin
        pulse_cnt = pulse_cnt - 1'b1;
        motor_lvl = 1'b1;
      end else begin
        motor_lvl = 1'b0;
        pulse_cnt = 8'(strength_reg);
      end
    end else begin
      motor_lvl = 1'b0;
      if (pause_cnt != 0) begin
        pause_cnt = pause_cnt - 1'b1;
      end else if (head_ptr != tail_ptr) begin
        buzz_cnt  = len_mem[head_ptr];
        pause_cnt = pau_mem[head_ptr];
        if (rep_mem[head_ptr] == 0) begin
          head_ptr = PtrW'((head_ptr + 1) % Depth);
        end else begin
          rep_mem[head_ptr] = rep_mem[head_ptr] - 1'b1;
        end
      end
    end
    duty = 0;
    if (pwm_mode && motor_lvl) begin
      duty = strength_reg * 20;
      if (duty > 100) begin
        duty = 100;
      end
    end
    st.motor   = motor_lvl;
    st.duty    = DutyW'(duty);
    st.busy    = (buzz_cnt != 0) || (pause_cnt != 0);
    st.pending = (head_ptr != tail_ptr);
  endtask

  always @(posedge clk_i) begin : drive_stim
    logic        nv;
    logic        ncv;
    logic        ngo;
    int unsigned n_sent;
    int unsigned gap_left;
    int unsigned settle;
    stim_op_t    op;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      cfg_if.valid <= 1'b0;
      sent_count   <= 0;
      hold_go      <= 1'b0;
      stim_done    <= 1'b0;
      gap_left     = 0;
      settle       = 0;
    end else begin
      n_sent = sent_count + ((in_if.valid && in_if.ready) ? 1 : 0);
      nv     = in_if.valid && !in_if.ready;
      ncv    = cfg_if.valid && !cfg_if.ready;
      ngo    = 1'b0;
      if (!nv && !ncv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          op = pending_q[0];
          case (op.kind)
            OP_ITEM: begin
              void'(pending_q.pop_front());
              nv                 = 1'b1;
              in_if.cmd          <= op.cmd;
              in_if.buzz_length  <= op.len;
              in_if.pause_length <= op.pau;
              in_if.repeat_count <= op.rep;
              in_if.preempt      <= op.now;
              gap_left           = op.gap;
              ngo                = op.hold;
            end
            OP_CFG: begin
              void'(pending_q.pop_front());
              ncv          = 1'b1;
              cfg_if.index <= op.idx;
              cfg_if.data  <= op.data;
            end
            default: begin
              // hold until every result is back, then let the pipeline settle
              if (n_sent == rx_count) begin
                if (settle >= SettleCyc) begin
                  void'(pending_q.pop_front());
                  settle = 0;
                end else begin
                  settle++;
                end
              end else begin
                settle = 0;
              end
            end
          endcase
        end
      end
      in_if.valid  <= nv;
      cfg_if.valid <= ncv;
      sent_count   <= n_sent;
      hold_go      <= ngo;
      stim_done    <= !nv && !ncv && (pending_q.size() == 0);
    end
  end

  always @(posedge clk_i) begin : hold_off
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HoldCyc;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : drive_ready
    int unsigned stall_left;
    int unsigned seg_left;
    bit          quiet;
    logic        rdy;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   = 0;
      seg_left     = 0;
      quiet        = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 200);
        quiet    = ($urandom_range(0, 2) == 0);
      end else begin
        seg_left--;
      end
      if (hold_left != 0) begin
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!quiet && ($urandom_range(0, 99) < 25)) begin
        stall_left = pick_gap();
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      res_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin : watch_motor
    motor_status_t want;
    motor_status_t got;
    if (!rst_ni) begin
      rx_count     <= 0;
      buzz_cnt     = '0;
      pause_cnt    = '0;
      pulse_cnt    = '0;
      head_ptr     = '0;
      tail_ptr     = '0;
      motor_lvl    = 1'b0;
      strength_reg = '0;
      pwm_mode     = 1'b0;
      for (int i = 0; i < Depth; i++) begin
        len_mem[i] = '0;
        pau_mem[i] = '0;
        rep_mem[i] = '0;
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          CFG_STRENGTH:   strength_reg = cfg_if.data[StrW-1:0];
          CFG_DRIVE_MODE: pwm_mode = cfg_if.data[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predict_motor(cmd_e'(in_if.cmd), in_if.buzz_length, in_if.pause_length,
                      in_if.repeat_count, in_if.preempt, want);
        motor_status_q.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        got.motor   = res_if.motor_on;
        got.duty    = res_if.duty_percent;
        got.busy    = res_if.busy_res;
        got.pending = res_if.queue_pending;
        if (motor_status_q.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = motor_status_q.pop_front();
          if (got.motor !== want.motor) begin
            report_mismatch("motor_on", got.motor, want.motor);
          end
          if (got.duty !== want.duty) begin
            report_mismatch("duty_percent", got.duty, want.duty);
          end
          if (got.busy !== want.busy) begin
            report_mismatch("busy_res", got.busy, want.busy);
          end
          if (got.pending !== want.pending) begin
            report_mismatch("queue_pending", got.pending, want.pending);
          end
        end
        rx_count <= rx_count + 1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCyc) begin
      $display("FAIL haptic_pattern_queue");
      $finish;
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned ph;
    int unsigned phase_len;
    logic [7:0]  data;
    logic [2:0]  s;
    logic        m;
    rst_ni              = 1'b0;
    cycle_count         = 0;
    err_count           = 0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_TICK;
    in_if.buzz_length   = '0;
    in_if.pause_length  = '0;
    in_if.repeat_count  = '0;
    in_if.preempt       = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_STRENGTH;
    cfg_if.data         = '0;
    res_if.ready        = 1'b0;
    dense_mode          = 1'b0;

    // directed: pulse train, idle start, queued repeat count of 14, full ring
    add_drain();
    add_cfg(CFG_STRENGTH, 8'd2);
    add_cfg(CFG_DRIVE_MODE, 8'd0);
    add_item(CMD_TICK, 8'hff, 8'hff, 4'd14, 1'b1, 1'b0);
    add_play(8'd3, 8'd2, 4'd0, 1'b0);
    add_play(8'd255, 8'd255, 4'd14, 1'b0);
    add_play(8'd0, 8'd0, 4'd0, 1'b0);
    add_ticks(6);
    add_play(8'd5, 8'd1, 4'd2, 1'b1);
    for (int unsigned i = 0; i < 8; i++) begin
      add_play(8'(i + 1), 8'(i), 4'(i % 3), 1'b0);
    end
    add_ticks(4);
    add_play(8'd2, 8'd0, 4'd0, 1'b1);
    add_ticks(2);

    n_rand = 0;
    for (ph = 0; n_rand < RandomItems; ph++) begin
      add_drain();
      case (ph)
        0: begin s = 3'd7; m = 1'b1; end
        1: begin s = 3'd0; m = 1'b1; end
        2: begin s = 3'd5; m = 1'b1; end
        3: begin s = 3'd0; m = 1'b0; end
        4: begin s = 3'd7; m = 1'b0; end
        default: begin s = 3'($urandom); m = 1'($urandom); end
      endcase
      data      = 8'($urandom);
      data[2:0] = s;
      add_cfg(CFG_STRENGTH, data);
      data      = 8'($urandom);
      data[0]   = m;
      add_cfg(CFG_DRIVE_MODE, data);
      dense_mode = (ph == 2) || (ph == 6) || ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(80, 200);
      for (int unsigned i = 0; (i < phase_len) && (n_rand < RandomItems); i++) begin
        add_random_item(((ph == 2) || (ph == 6)) && (i == 30));
        n_rand++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_done && (rx_count == sent_count));
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
    if (motor_status_q.size() != 0) begin
      report_mismatch("results outstanding", 0, motor_status_q.size());
    end
    if (err_count == 0) begin
      $display("PASS haptic_pattern_queue");
    end else begin
      $display("FAIL haptic_pattern_queue");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hpq_pkg.sv
hw/rtl/hpq_if.sv
hw/rtl/hpq_ring.sv
hw/rtl/hpq_timer.sv
hw/rtl/haptic_pattern_queue.sv
bench/tb_haptic_pattern_queue.sv
